// ===== rtl/core/gde_pkg.sv =====
// shared types and constants of the graph depth-first search engine
package gde_pkg;

    localparam int NODE_W = 7;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;

    localparam logic [MODE_W-1:0] MODE_ADD_NODE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_EDGE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ELEN,
        ST_ERD,
        ST_ECMP,
        ST_EAPP,
        ST_RESP,
        ST_SINIT,
        ST_TOP,
        ST_NBR,
        ST_PUSH,
        ST_POPLD,
        ST_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_EDGE_INIT,
        OP_EDGE_RD,
        OP_EDGE_CMP,
        OP_EDGE_APP,
        OP_EMIT_STATUS,
        OP_SRCH_INIT,
        OP_POP,
        OP_POP_LD,
        OP_NBR_RD,
        OP_CNT_RD_NBR,
        OP_PUSH,
        OP_EMIT_LAST
    } t_dp_op;

    typedef struct packed {
        logic edge_ok;
        logic dst_ok;
        logic edge_done;
        logic sp_zero;
        logic sp_one;
        logic top_empty;
        logic nbr_take;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/gde_datapath.sv =====
// datapath: node count, adjacency memories, walk stack, visited map, result register
module gde_datapath
    import gde_pkg::*;
#(
    parameter int NODES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [NODE_W-1:0] i_cfg_wr_data,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [NODE_W-1:0] i_src,
    input  logic [NODE_W-1:0] i_dst,
    input  t_dp_op            i_op,
    output t_dp_stat          o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [NODE_W-1:0] o_out_node,
    output logic [STAT_W-1:0] o_out_status,
    output logic              o_out_last
);

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W = $clog2(NODES + 1);
    localparam int STK_W = IDX_W + CNT_W;
    localparam int LST_DEPTH = 1 << (2 * IDX_W);

    logic [CNT_W-1:0]  r_node_count;
    logic [IDX_W-1:0]  r_src, r_dst, r_v;
    logic [STAT_W-1:0] r_resp_status;
    logic [CNT_W-1:0]  r_i, r_w, r_n;
    logic [CNT_W-1:0]  r_cnt_mem [NODES];
    logic [NODES-1:0]  r_cnt_vld;
    logic [CNT_W-1:0]  r_cnt_q;
    logic [IDX_W-1:0]  r_lst_mem [LST_DEPTH];
    logic [IDX_W-1:0]  r_lst_q;
    logic [STK_W-1:0]  r_stk_mem [NODES];
    logic [STK_W-1:0]  r_stk_q;
    logic [IDX_W-1:0]  r_top_node;
    logic [CNT_W-1:0]  r_top_pos;
    logic [CNT_W-1:0]  r_sp, r_k;
    logic [NODES-1:0]  r_visited;
    logic [NODE_W-1:0] r_pend;
    logic              r_out_valid;
    logic [NODE_W-1:0] r_out_node;
    logic [STAT_W-1:0] r_out_status;
    logic              r_out_last;

    logic              src_ok, dst_ok, full, out_free;
    logic [IDX_W-1:0]  src_idx, dst_idx;
    logic              cnt_rd_en, cnt_wr_en, lst_rd_en, lst_wr_en, stk_rd_en, stk_wr_en;
    logic [IDX_W-1:0]  cnt_rd_addr, cnt_wr_addr, stk_rd_addr, stk_wr_addr;
    logic [CNT_W-1:0]  cnt_wr_data;
    logic [2*IDX_W-1:0] lst_rd_addr, lst_wr_addr;
    logic [IDX_W-1:0]  lst_wr_data;
    logic              out_load;
    logic [NODE_W-1:0] out_node_d;
    logic [STAT_W-1:0] out_status_d;
    logic              out_last_d;
    logic [CNT_W-1:0]  pos_dec;

    assign src_ok  = (i_src != '0) && (i_src <= NODE_W'(r_node_count));
    assign dst_ok  = (i_dst != '0) && (i_dst <= NODE_W'(r_node_count));
    assign full    = (r_node_count == CNT_W'(NODES));
    assign src_idx = IDX_W'(i_src - NODE_W'(1));
    assign dst_idx = IDX_W'(i_dst - NODE_W'(1));
    assign out_free = !r_out_valid || i_out_ready;
    assign pos_dec  = r_top_pos - CNT_W'(1);

    assign o_stat.edge_ok   = src_ok && dst_ok;
    assign o_stat.dst_ok    = dst_ok;
    assign o_stat.edge_done = (r_i == r_n);
    assign o_stat.sp_zero   = (r_sp == '0);
    assign o_stat.sp_one    = (r_sp == CNT_W'(1));
    assign o_stat.top_empty = (r_top_pos == '0);
    assign o_stat.nbr_take  = !r_visited[r_lst_q] && (r_k < CNT_W'(NODES))
                              && (r_sp < CNT_W'(NODES));
    assign o_stat.out_free  = out_free;

    // memory port control per datapath operation
    always_comb begin
        cnt_rd_en    = 1'b0;
        cnt_rd_addr  = dst_idx;
        cnt_wr_en    = 1'b0;
        cnt_wr_addr  = r_src;
        cnt_wr_data  = r_w;
        lst_rd_en    = 1'b0;
        lst_rd_addr  = {r_src, r_i[IDX_W-1:0]};
        lst_wr_en    = 1'b0;
        lst_wr_addr  = {r_src, r_w[IDX_W-1:0]};
        lst_wr_data  = r_lst_q;
        stk_rd_en    = 1'b0;
        stk_rd_addr  = IDX_W'(r_sp - CNT_W'(2));
        stk_wr_en    = 1'b0;
        stk_wr_addr  = IDX_W'(r_sp - CNT_W'(1));
        out_load     = 1'b0;
        out_node_d   = r_pend;
        out_status_d = STAT_OK;
        out_last_d   = 1'b0;
        case (i_op)
            OP_ACCEPT: begin
                cnt_rd_en   = 1'b1;
                cnt_rd_addr = (i_mode == MODE_ADD_EDGE) ? src_idx : dst_idx;
            end
            OP_EDGE_RD: begin
                lst_rd_en = 1'b1;
            end
            OP_EDGE_CMP: begin
                lst_wr_en = (r_lst_q != r_dst);
            end
            OP_EDGE_APP: begin
                cnt_wr_en = 1'b1;
                if (r_w < CNT_W'(NODES)) begin
                    lst_wr_en   = 1'b1;
                    lst_wr_data = r_dst;
                    cnt_wr_data = r_w + CNT_W'(1);
                end
            end
            OP_EMIT_STATUS: begin
                out_load     = 1'b1;
                out_node_d   = '0;
                out_status_d = r_resp_status;
                out_last_d   = 1'b1;
            end
            OP_POP: begin
                stk_rd_en = 1'b1;
            end
            OP_NBR_RD: begin
                lst_rd_en   = 1'b1;
                lst_rd_addr = {r_top_node, pos_dec[IDX_W-1:0]};
            end
            OP_CNT_RD_NBR: begin
                cnt_rd_en   = 1'b1;
                cnt_rd_addr = r_lst_q;
            end
            OP_PUSH: begin
                stk_wr_en = 1'b1;
                out_load  = 1'b1;
            end
            OP_EMIT_LAST: begin
                out_load   = 1'b1;
                out_last_d = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // neighbor count memory, entries read as zero until first written
    always_ff @(posedge i_clk) begin
        if (cnt_wr_en) begin
            r_cnt_mem[cnt_wr_addr] <= cnt_wr_data;
        end
        if (cnt_rd_en) begin
            r_cnt_q <= r_cnt_vld[cnt_rd_addr] ? r_cnt_mem[cnt_rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
        end else if (cnt_wr_en) begin
            r_cnt_vld[cnt_wr_addr] <= 1'b1;
        end
    end

    // neighbor list memory
    always_ff @(posedge i_clk) begin
        if (lst_wr_en) begin
            r_lst_mem[lst_wr_addr] <= lst_wr_data;
        end
        if (lst_rd_en) begin
            r_lst_q <= r_lst_mem[lst_rd_addr];
        end
    end

    // walk stack below the top entry
    always_ff @(posedge i_clk) begin
        if (stk_wr_en) begin
            r_stk_mem[stk_wr_addr] <= {r_top_node, r_top_pos};
        end
        if (stk_rd_en) begin
            r_stk_q <= r_stk_mem[stk_rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_sp         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_node_count <= (i_cfg_wr_data > NODE_W'(NODES)) ? CNT_W'(NODES)
                                                                  : CNT_W'(i_cfg_wr_data);
            end else if (i_op == OP_ACCEPT && i_mode == MODE_ADD_NODE && !full) begin
                r_node_count <= r_node_count + CNT_W'(1);
            end
            case (i_op)
                OP_SRCH_INIT: r_sp <= CNT_W'(1);
                OP_POP:       r_sp <= r_sp - CNT_W'(1);
                OP_PUSH:      r_sp <= r_sp + CNT_W'(1);
                default:      r_sp <= r_sp;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_node   <= out_node_d;
            r_out_status <= out_status_d;
            r_out_last   <= out_last_d;
        end
        case (i_op)
            OP_ACCEPT: begin
                r_src <= src_idx;
                r_dst <= dst_idx;
                case (i_mode)
                    MODE_ADD_NODE: r_resp_status <= full ? STAT_FULL : STAT_OK;
                    MODE_ADD_EDGE: r_resp_status <= (src_ok && dst_ok) ? STAT_OK
                                                                       : STAT_INVALID;
                    default:       r_resp_status <= dst_ok ? STAT_OK : STAT_INVALID;
                endcase
            end
            OP_EDGE_INIT: begin
                r_n <= r_cnt_q;
                r_i <= '0;
                r_w <= '0;
            end
            OP_EDGE_CMP: begin
                r_i <= r_i + CNT_W'(1);
                if (r_lst_q != r_dst) begin
                    r_w <= r_w + CNT_W'(1);
                end
            end
            OP_SRCH_INIT: begin
                // fresh map with only the start node marked
                r_visited        <= NODES'(1) << r_dst;
                r_pend           <= NODE_W'(r_dst) + NODE_W'(1);
                r_k              <= CNT_W'(1);
                r_top_node       <= r_dst;
                r_top_pos        <= r_cnt_q;
            end
            OP_POP_LD: begin
                {r_top_node, r_top_pos} <= r_stk_q;
            end
            OP_NBR_RD: begin
                r_top_pos <= pos_dec;
            end
            OP_CNT_RD_NBR: begin
                r_v <= r_lst_q;
            end
            OP_PUSH: begin
                r_visited[r_v] <= 1'b1;
                r_pend         <= NODE_W'(r_v) + NODE_W'(1);
                r_k            <= r_k + CNT_W'(1);
                r_top_node     <= r_v;
                r_top_pos      <= r_cnt_q;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_node   = r_out_node;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CNT_W'(NODES))
        else $error("walk stack depth beyond node limit");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_node_count <= CNT_W'(NODES))
        else $error("node count beyond node limit");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result register overwritten while full");

    a_last_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_EMIT_LAST) |=> (r_out_valid && r_out_last))
        else $error("final search item not presented");

endmodule

// ===== rtl/core/gde_ctrl.sv =====
// controller state machine sequencing node, edge and search operations
module gde_ctrl
    import gde_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  t_dp_stat          i_stat,
    output t_dp_op            o_op
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op = OP_ACCEPT;
                    case (i_mode)
                        MODE_ADD_NODE: n_state = ST_RESP;
                        MODE_ADD_EDGE: n_state = i_stat.edge_ok ? ST_ELEN : ST_RESP;
                        MODE_SEARCH:   n_state = i_stat.dst_ok ? ST_SINIT : ST_RESP;
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ELEN: begin
                o_op    = OP_EDGE_INIT;
                n_state = ST_ERD;
            end
            ST_ERD: begin
                if (i_stat.edge_done) begin
                    n_state = ST_EAPP;
                end else begin
                    o_op    = OP_EDGE_RD;
                    n_state = ST_ECMP;
                end
            end
            ST_ECMP: begin
                o_op    = OP_EDGE_CMP;
                n_state = ST_ERD;
            end
            ST_EAPP: begin
                o_op    = OP_EDGE_APP;
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_stat.out_free) begin
                    o_op    = OP_EMIT_STATUS;
                    n_state = ST_IDLE;
                end
            end
            ST_SINIT: begin
                o_op    = OP_SRCH_INIT;
                n_state = ST_TOP;
            end
            ST_TOP: begin
                if (i_stat.sp_zero) begin
                    n_state = ST_FIN;
                end else if (i_stat.top_empty) begin
                    o_op    = OP_POP;
                    n_state = i_stat.sp_one ? ST_TOP : ST_POPLD;
                end else begin
                    o_op    = OP_NBR_RD;
                    n_state = ST_NBR;
                end
            end
            ST_NBR: begin
                if (i_stat.nbr_take) begin
                    o_op    = OP_CNT_RD_NBR;
                    n_state = ST_PUSH;
                end else begin
                    n_state = ST_TOP;
                end
            end
            ST_PUSH: begin
                if (i_stat.out_free) begin
                    o_op    = OP_PUSH;
                    n_state = ST_TOP;
                end
            end
            ST_POPLD: begin
                o_op    = OP_POP_LD;
                n_state = ST_TOP;
            end
            ST_FIN: begin
                if (i_stat.out_free) begin
                    o_op    = OP_EMIT_LAST;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_ACCEPT) |-> (r_state == ST_IDLE && i_in_valid))
        else $error("item taken outside idle");

    a_push_after_nbr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_PUSH) |-> ($past(r_state) == ST_NBR || $past(r_state) == ST_PUSH))
        else $error("push without neighbor check");

    a_edge_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_EDGE_RD) |=> (o_op == OP_EDGE_CMP))
        else $error("edge compare missing after read");

endmodule

// ===== rtl/core/graph_dfs_engine.sv =====
// top level of the graph depth-first search engine
// add node and rejected items give their one result; add edge gives one result after
//   reading each of the source's neighbor entries once
// search: one result per node reached, the final one with tlast, after reading
//   each neighbor entry walked
// one item at a time: a new item is taken once the last result is in the output register
// reset (synchronous, active low) empties the graph: node count 0, all neighbor counts 0
module graph_dfs_engine
    import gde_pkg::*;
#(
    parameter int NODES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: node count load
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    // input item stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [6:0] source_node, [13:7] target_node, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // result item stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] visited_node, [7] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast    // final item of one input item
);

    t_dp_op            op;
    t_dp_stat          stat;
    logic [NODE_W-1:0] out_node;

    // controller: decides the next step from datapath status flags
    gde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_mode     (s_axis_tuser),
        .i_stat     (stat),
        .o_op       (op)
    );

    // datapath: memories, walk stack and the output register
    gde_datapath #(
        .NODES (NODES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_mode        (s_axis_tuser),
        .i_src         (s_axis_tdata[6:0]),
        .i_dst         (s_axis_tdata[13:7]),
        .i_op          (op),
        .o_stat        (stat),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_node    (out_node),
        .o_out_status  (m_axis_tuser),
        .o_out_last    (m_axis_tlast)
    );

    // pad the node number to a whole byte
    assign m_axis_tdata = {1'b0, out_node};

endmodule
